// ===== rtl/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants of the peer address table.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int unsigned IDENT_W     = 16;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned DEPTH_DFLT  = 128;

  // Operation codes; the fourth code is unused and fails without effect
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } opcode_e;

  // One stored table entry
  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/pat_if.sv =====
// ----------------------------------------------------------------------------
// pat_req_if / pat_rsp_if
// Valid/ready channels carrying table requests and their results.
// ----------------------------------------------------------------------------
interface pat_req_if
  import pat_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [IDENT_W-1:0]  peer_ident;
  logic [IP_W-1:0]     ip_address;
  logic [PORT_W-1:0]   port_number;

  modport source (output valid, opcode, peer_ident, ip_address, port_number,
                  input ready);
  modport sink   (input valid, opcode, peer_ident, ip_address, port_number,
                  output ready);
endinterface

interface pat_rsp_if
  import pat_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                failed;
  logic [IDENT_W-1:0]  found_ident;

  modport source (output valid, failed, found_ident, input ready);
  modport sink   (input valid, failed, found_ident, output ready);
endinterface

// ===== rtl/pat_ram.sv =====
// ----------------------------------------------------------------------------
// pat_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/peer_address_table.sv =====
// ----------------------------------------------------------------------------
// peer_address_table
// Compact peer table with add, remove-by-identifier and find-by-address.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction (opcode, peer_ident,
//   ip_address, port_number); rsp_o returns exactly one result per
//   operation (failed, found_ident), in order.
//   Entries live in one RAM at positions 0 .. count-1 with no holes.
//   Every add, remove and find walks the occupied entries through the RAM
//   read port, one entry per cycle, until a match or the end of the table;
//   an add on a full table and the unused opcode skip the scan. Remove
//   then reads the last entry and moves it into the hole. The next
//   operation is accepted once the result is registered.
//   One operation is in flight at a time; req_i.ready is high while idle.
//   The output register holds a result while rsp_o is stalled; the next
//   operation is accepted meanwhile and waits for the register to drain
//   before it delivers its own result.
//   Reset empties the table at once (count to zero); RAM contents are
//   never cleared since only written entries below the count are read.
// ----------------------------------------------------------------------------
module peer_address_table
  import pat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pat_req_if.sink     req_i,
  pat_rsp_if.source   rsp_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_MOVE,
    ST_RESP
  } state_e;

  state_e             state_q;
  opcode_e            op_q;
  logic [IDENT_W-1:0] ident_q;
  logic [IP_W-1:0]    ip_q;
  logic [PORT_W-1:0]  port_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic               cmp_v_q;
  logic [AW-1:0]      cmp_idx_q;
  logic [AW-1:0]      hit_idx_q;
  logic               res_fail_q;
  logic [IDENT_W-1:0] res_ident_q;
  logic               rsp_valid_q;
  logic               rsp_fail_q;
  logic [IDENT_W-1:0] rsp_ident_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [CW-1:0]      last_idx;
  logic               issue;
  logic               match;
  logic               hit;
  logic               miss;
  logic               rsp_free;
  logic               cmp_v_d;
  logic               rsp_valid_d;

  pat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Compare the entry returned by the RAM against the search key
  always_comb begin
    case (op_q)
      OP_FIND: match = (ram_rdata.ip == ip_q) && (ram_rdata.port == port_q);
      default: match = (ram_rdata.ident == ident_q);
    endcase
  end

  assign last_idx = count_q - 1'b1;
  assign issue    = (idx_q < count_q);
  assign hit      = (state_q == ST_SCAN) && cmp_v_q && match;
  assign miss     = (state_q == ST_SCAN) && !cmp_v_q && !issue;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  // Flag a compare next cycle whenever a scan read is issued
  assign cmp_v_d = (state_q == ST_SCAN) && !hit && issue;

  // Load the output register when a result is ready, hold it while stalled
  assign rsp_valid_d = ((state_q == ST_RESP) && rsp_free) ||
                       (rsp_valid_q && !rsp_o.ready);

  // Drive the RAM: scan reads, append on add, hole fill on remove
  assign ram_raddr = (state_q == ST_LAST) ? last_idx[AW-1:0] : idx_q[AW-1:0];
  assign ram_we    = (miss && (op_q == OP_ADD)) || (state_q == ST_MOVE);
  assign ram_waddr = (state_q == ST_MOVE) ? hit_idx_q : count_q[AW-1:0];
  always_comb begin
    if (state_q == ST_MOVE) begin
      ram_wdata = ram_rdata;
    end else begin
      ram_wdata.ident = ident_q;
      ram_wdata.ip    = ip_q;
      ram_wdata.port  = port_q;
    end
  end

  // Sequence one operation at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      cmp_v_q     <= cmp_v_d;
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            ident_q     <= req_i.peer_ident;
            ip_q        <= req_i.ip_address;
            port_q      <= req_i.port_number;
            idx_q       <= '0;
            res_fail_q  <= 1'b1;
            res_ident_q <= '0;
            case (req_i.opcode)
              OP_ADD: begin
                op_q    <= OP_ADD;
                state_q <= (count_q == FULL) ? ST_RESP : ST_SCAN;
              end
              OP_REMOVE: begin
                op_q    <= OP_REMOVE;
                state_q <= ST_SCAN;
              end
              OP_FIND: begin
                op_q    <= OP_FIND;
                state_q <= ST_SCAN;
              end
              default: begin
                op_q    <= OP_FIND;
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            case (op_q)
              OP_REMOVE: begin
                hit_idx_q <= cmp_idx_q;
                state_q   <= ST_LAST;
              end
              OP_FIND: begin
                res_fail_q  <= 1'b0;
                res_ident_q <= ram_rdata.ident;
                state_q     <= ST_RESP;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end else if (miss) begin
            if (op_q == OP_ADD) begin
              count_q    <= count_q + 1'b1;
              res_fail_q <= 1'b0;
            end
            state_q <= ST_RESP;
          end else if (issue) begin
            // Advance the read pointer; data arrives next cycle
            idx_q     <= idx_q + 1'b1;
            cmp_idx_q <= idx_q[AW-1:0];
          end
        end
        ST_LAST: begin
          state_q <= ST_MOVE;
        end
        ST_MOVE: begin
          count_q    <= last_idx;
          res_fail_q <= 1'b0;
          state_q    <= ST_RESP;
        end
        ST_RESP: begin
          // Hold until the output register is free
          if (rsp_free) begin
            rsp_fail_q  <= res_fail_q;
            rsp_ident_q <= res_ident_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.failed      = rsp_fail_q;
  assign rsp_o.found_ident = rsp_ident_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("occupancy exceeds table depth");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> ({1'b0, cmp_idx_q} < {1'b0, count_q}))
    else $error("compare of an entry beyond the count");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_SCAN) || (state_q == ST_MOVE)))
    else $error("RAM write outside append or hole fill");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == ST_SCAN || $past(state_q) == ST_MOVE))
    else $error("count changed outside an add or remove");

  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAST) |-> (count_q != '0))
    else $error("hole fill on an empty table");

endmodule
